// File: rtl/tcng_pkg.sv
package tcng_pkg;

    // Cipher constants
    localparam int unsigned TEA_ROUNDS = 32;
    localparam logic [31:0] TEA_DELTA  = 32'h9e37_79b9;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_WORD_ZERO   = 3'd0,
        REG_KEY_WORD_ONE    = 3'd1,
        REG_KEY_WORD_TWO    = 3'd2,
        REG_KEY_WORD_THREE  = 3'd3,
        REG_KEYED_MODE      = 3'd4,
        REG_SEPARATION_MASK = 3'd5,
        REG_SEPARATION_DATA = 3'd6,
        REG_COUNTER_START   = 3'd7
    } cfg_reg_t;

    // Settings seen by the datapath
    typedef struct packed {
        logic [3:0][31:0] key;
        logic             keyed_mode;
        logic [31:0]      separation_mask;
        logic [31:0]      separation_data;
    } tcng_cfg_t;

    // Counter load request from the register file
    typedef struct packed {
        logic        load;
        logic [63:0] value;
    } tcng_load_t;

    // Payload of one pipeline stage
    typedef struct packed {
        logic [31:0] prefix_word;
        logic [31:0] v1;
        logic [31:0] v0;
    } tcng_stage_t;

    // Running sum of delta after round r (r counts from 0)
    function automatic logic [31:0] tea_sum(input int r);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i <= r; i++)
        begin
            s = s + TEA_DELTA;
        end
        return s;
    endfunction

    // One full TEA round: v0 then v1
    function automatic logic [63:0] tea_round(input logic [31:0] v0,
                                              input logic [31:0] v1,
                                              input logic [31:0] sum,
                                              input logic [3:0][31:0] key);
        logic [31:0] n0;
        logic [31:0] n1;
        n0 = v0 + (((v1 << 4) + key[0]) ^ (v1 + sum) ^ ((v1 >> 5) + key[1]));
        n1 = v1 + (((n0 << 4) + key[2]) ^ (n0 + sum) ^ ((n0 >> 5) + key[3]));
        return {n1, n0};
    endfunction

endpackage

// File: rtl/tcng_cfg.sv
module tcng_cfg
    import tcng_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output tcng_cfg_t              cfg,
    output tcng_load_t             cnt_load
);

    tcng_cfg_t cfg_reg;
    tcng_cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        cnt_load.load  = 1'b0;
        cnt_load.value = cfg_wdata;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_WORD_ZERO:   cfg_next.key[0] = cfg_wdata[31:0];
                REG_KEY_WORD_ONE:    cfg_next.key[1] = cfg_wdata[31:0];
                REG_KEY_WORD_TWO:    cfg_next.key[2] = cfg_wdata[31:0];
                REG_KEY_WORD_THREE:  cfg_next.key[3] = cfg_wdata[31:0];
                REG_KEYED_MODE:      cfg_next.keyed_mode = cfg_wdata[0];
                REG_SEPARATION_MASK: cfg_next.separation_mask = cfg_wdata[31:0];
                REG_SEPARATION_DATA: cfg_next.separation_data = cfg_wdata[31:0];
                REG_COUNTER_START:   cnt_load.load = 1'b1;
                default:             cnt_load.load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key             <= '0;
            cfg_reg.keyed_mode      <= 1'b0;
            cfg_reg.separation_mask <= 32'hffff_ffff;
            cfg_reg.separation_data <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tcng_front.sv
module tcng_front
    import tcng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tcng_cfg_t   cfg,
    input  tcng_load_t  cnt_load,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] random_word,
    output logic        out_valid,
    input  logic        out_ready,
    output tcng_stage_t out_data
);

    logic [63:0] cnt_reg;
    logic [63:0] cnt_next;
    logic        valid_reg;
    logic        valid_next;
    tcng_stage_t data_reg;
    tcng_stage_t data_next;
    logic        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Counter: load from config wins, else advance per request
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cnt_load.load)
        begin
            cnt_next = cnt_load.value;
        end
        else if (accept)
        begin
            cnt_next = cnt_reg + 64'd1;
        end
    end

    // Prefix lanes and the new counter value
    always_comb
    begin
        for (int lane = 0; lane < 4; lane++)
        begin
            data_next.prefix_word[lane*8 +: 8] =
                (random_word[lane*8 +: 8] & cfg.separation_mask[lane*8 +: 8])
                + cfg.separation_data[lane*8 +: 8];
        end
        {data_next.v1, data_next.v0} = cnt_reg + 64'd1;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Counter advances by one per accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cnt_load.load |=> cnt_reg == $past(cnt_reg) + 64'd1)
        else $error("counter did not advance on request");

    // Start register write loads the counter
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_load.load |=> cnt_reg == $past(cnt_load.value))
        else $error("counter load lost");

    // Empty stage always takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("empty front stage stalled");

    // Stored item carries the advanced counter
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cnt_load.load |=> {data_reg.v1, data_reg.v0} == cnt_reg)
        else $error("stage counter mismatch");

endmodule

// File: rtl/tcng_round.sv
module tcng_round
    import tcng_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             keyed_mode,
    input  logic [3:0][31:0] key,
    input  logic [31:0]      sum,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcng_stage_t      in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tcng_stage_t      out_data
);

    logic        valid_reg;
    logic        valid_next;
    tcng_stage_t data_reg;
    tcng_stage_t data_next;
    logic        accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // One cipher round, bypassed in plain mode
    always_comb
    begin
        data_next = in_data;
        if (keyed_mode)
        begin
            {data_next.v1, data_next.v0} = tea_round(in_data.v0, in_data.v1, sum, key);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/tea_counter_nonce_generator_core.sv
// Pipeline: one input stage, then one registered stage per cipher round; the
// last round stage is the output.
// Throughput: one request per cycle while m_tready is high; each stage holds its item only while the
// next stage is full and stalled, so empty stages keep taking requests.
// Reset (rst_n, async, active low): counter zero, keys zero, plain mode,
// mask all ones, data zero, pipeline empty.
module tea_counter_nonce_generator_core
    import tcng_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,  // [31:0] random_word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [95:0]            m_tdata,  // [31:0] prefix_word, [95:32] counter_block
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    tcng_cfg_t   cfg;
    tcng_load_t  cnt_load;
    tcng_stage_t stage_data  [TEA_ROUNDS+1];
    logic        stage_valid [TEA_ROUNDS+1];
    logic        stage_ready [TEA_ROUNDS+1];

    // Configuration registers
    tcng_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .cnt_load  (cnt_load)
    );

    // Input stage: prefix and counter
    tcng_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cnt_load    (cnt_load),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .random_word (s_tdata),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_data    (stage_data[0])
    );

    // Unrolled cipher rounds
    for (genvar g = 0; g < TEA_ROUNDS; g++)
    begin : g_round
        localparam logic [31:0] RoundSum = tea_sum(g);

        tcng_round u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .keyed_mode (cfg.keyed_mode),
            .key        (cfg.key),
            .sum        (RoundSum),
            .in_valid   (stage_valid[g]),
            .in_ready   (stage_ready[g]),
            .in_data    (stage_data[g]),
            .out_valid  (stage_valid[g+1]),
            .out_ready  (stage_ready[g+1]),
            .out_data   (stage_data[g+1])
        );
    end

    // Result port
    assign stage_ready[TEA_ROUNDS] = m_tready;
    assign m_tvalid = stage_valid[TEA_ROUNDS];
    assign m_tdata  = {stage_data[TEA_ROUNDS].v1, stage_data[TEA_ROUNDS].v0,
                       stage_data[TEA_ROUNDS].prefix_word};

endmodule

// File: tb/tb_tea_counter_nonce_generator_core.sv
module tb_tea_counter_nonce_generator_core
    import tcng_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_WORDS   = 106;

    // One nonce as the block emits it
    typedef struct packed {
        logic [63:0] counter_block;
        logic [31:0] prefix_word;
    } nonce_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;    // [31:0] random_word
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [95:0]            m_tdata;         // [31:0] prefix_word, [95:32] counter_block
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Local copy of the block's settings and counter
    logic [31:0] tea_key [4] = '{default: '0};
    logic        keyed = 1'b0;
    logic [31:0] sep_mask = 32'hFFFF_FFFF;
    logic [31:0] sep_data = '0;
    logic [63:0] counter_value = '0;

    logic [31:0] random_word_backlog [$];
    nonce_t      nonces_in_flight [$];
    nonce_t      oldest_nonce;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    tea_counter_nonce_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // TEA encipher of the counter, low word v0, high word v1
    function automatic logic [63:0] tea_encipher_block(input logic [63:0] blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] acc;
        v0  = blk[31:0];
        v1  = blk[63:32];
        acc = '0;
        for (int r = 0; r < TEA_ROUNDS; r++)
        begin
            acc = acc + TEA_DELTA;
            v0  = v0 + (((v1 << 4) + tea_key[0]) ^ (v1 + acc) ^ ((v1 >> 5) + tea_key[1]));
            v1  = v1 + (((v0 << 4) + tea_key[2]) ^ (v0 + acc) ^ ((v0 >> 5) + tea_key[3]));
        end
        return {v1, v0};
    endfunction

    // Masked prefix bytes plus data bytes (no carry between bytes), then counter
    function automatic nonce_t build_nonce(input logic [31:0] rnd, input logic [63:0] count);
        nonce_t n;
        for (int b = 0; b < 4; b++)
        begin
            n.prefix_word[8*b +: 8] = (rnd[8*b +: 8] & sep_mask[8*b +: 8]) + sep_data[8*b +: 8];
        end
        n.counter_block = keyed ? tea_encipher_block(count) : count;
        return n;
    endfunction

    // Register values with junk above the register width
    function automatic logic [63:0] widen(input logic [31:0] word);
        return {$urandom, word};
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_count();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(80));
            2:       return 64'h0000_0000_FFFF_FFFF - 64'($urandom_range(80));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Request driver; predicts each nonce as its request is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                counter_value = counter_value + 64'd1;
                nonces_in_flight.push_back(build_nonce(s_tdata, counter_value));
            end
            if (!s_tvalid || s_tready)
            begin
                if (random_word_backlog.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    s_tdata  <= random_word_backlog.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (nonces_in_flight.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    oldest_nonce = nonces_in_flight.pop_front();
                    if (m_tdata[31:0] !== oldest_nonce.prefix_word)
                    begin
                        $display("%0t: prefix_word expected %h got %h", $time,
                                 oldest_nonce.prefix_word, m_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_tdata[95:32] !== oldest_nonce.counter_block)
                    begin
                        $display("%0t: counter_block expected %h got %h", $time,
                                 oldest_nonce.counter_block, m_tdata[95:32]);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Register write; the local copy follows at once since the block is idle
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_KEY_WORD_ZERO:   tea_key[0] = value[31:0];
            REG_KEY_WORD_ONE:    tea_key[1] = value[31:0];
            REG_KEY_WORD_TWO:    tea_key[2] = value[31:0];
            REG_KEY_WORD_THREE:  tea_key[3] = value[31:0];
            REG_KEYED_MODE:      keyed = value[0];
            REG_SEPARATION_MASK: sep_mask = value[31:0];
            REG_SEPARATION_DATA: sep_data = value[31:0];
            REG_COUNTER_START:   counter_value = value;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_keys(input logic [31:0] k0, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3);
        write_reg(REG_KEY_WORD_ZERO, widen(k0));
        write_reg(REG_KEY_WORD_ONE, widen(k1));
        write_reg(REG_KEY_WORD_TWO, widen(k2));
        write_reg(REG_KEY_WORD_THREE, widen(k3));
    endtask

    // Wait until every request is taken and every nonce has come back
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (random_word_backlog.size() != 0 || s_tvalid || nonces_in_flight.size() != 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: plain counter from zero, full random prefix
        random_word_backlog.push_back(32'h0000_0000);
        random_word_backlog.push_back(32'hFFFF_FFFF);
        random_word_backlog.push_back(32'h5555_5555);
        random_word_backlog.push_back(32'hAAAA_AAAA);
        wait_drained();

        // Mask clears all random bits, data all ones
        write_reg(REG_SEPARATION_MASK, widen(32'h0000_0000));
        write_reg(REG_SEPARATION_DATA, widen(32'hFFFF_FFFF));
        end_writes();
        random_word_backlog.push_back(32'h1234_5678);
        random_word_backlog.push_back(32'hFFFF_FFFF);
        wait_drained();

        // Byte sums overflow without carrying into the next byte
        write_reg(REG_SEPARATION_MASK, widen(32'hFFFF_FFFF));
        write_reg(REG_SEPARATION_DATA, widen(32'h0101_0101));
        end_writes();
        random_word_backlog.push_back(32'hFFFF_FFFF);
        random_word_backlog.push_back(32'hFEFF_00FF);
        wait_drained();
        write_reg(REG_SEPARATION_MASK, widen(32'h0F0F_F0F0));
        write_reg(REG_SEPARATION_DATA, widen(32'h80FF_7F01));
        end_writes();
        random_word_backlog.push_back($urandom);
        random_word_backlog.push_back($urandom);
        wait_drained();

        // Plain counter wraps through zero
        write_reg(REG_COUNTER_START, 64'hFFFF_FFFF_FFFF_FFFE);
        end_writes();
        repeat (3) random_word_backlog.push_back($urandom);
        wait_drained();

        // Keyed mode, all-ones key, counter wraps to zero
        write_keys('1, '1, '1, '1);
        write_reg(REG_KEYED_MODE, {$urandom, $urandom} | 64'd1);
        write_reg(REG_COUNTER_START, 64'hFFFF_FFFF_FFFF_FFFF);
        end_writes();
        repeat (2) random_word_backlog.push_back($urandom);
        wait_drained();

        // All-zero key
        write_keys('0, '0, '0, '0);
        end_writes();
        repeat (2) random_word_backlog.push_back($urandom);
        wait_drained();

        // Only bit 0 of keyed_mode counts
        write_reg(REG_KEYED_MODE, {$urandom, $urandom} & ~64'd1);
        end_writes();
        random_word_backlog.push_back($urandom);
        wait_drained();

        // Carry from low into high counter word, keyed
        write_keys(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
        write_reg(REG_KEYED_MODE, 64'd1);
        write_reg(REG_COUNTER_START, 64'h0000_0000_FFFF_FFFF);
        end_writes();
        repeat (2) random_word_backlog.push_back($urandom);
        wait_drained();

        // Random phases with new settings and idle pattern each time
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            write_keys(pick_word(), pick_word(), pick_word(), pick_word());
            write_reg(REG_KEYED_MODE, {$urandom, $urandom});
            write_reg(REG_SEPARATION_MASK, widen(pick_word()));
            write_reg(REG_SEPARATION_DATA, widen(pick_word()));
            write_reg(REG_COUNTER_START, pick_count());
            end_writes();
            repeat (PHASE_WORDS) random_word_backlog.push_back($urandom);
            wait_drained();
        end

        // Let any stray result show up
        repeat (TEA_ROUNDS + 8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
